@@ rtl/wrpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512a generator package
// Shared widths, request codes, recurrence constants and the command and
// status types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wrpg_pkg;

    localparam int WORD_W     = 32;
    localparam int REQ_W      = 2;
    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = 4;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 5;
    localparam int OP_W       = 4;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SEED    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RAW     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BOUNDED = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

    // Recurrence constants.
    localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA442D24;
    localparam logic [IDX_W-1:0]  OFS_C       = 4'd13;
    localparam logic [IDX_W-1:0]  OFS_V       = 4'd9;
    localparam logic [IDX_W-1:0]  OFS_M       = 4'd15;

    // Datapath operation codes.
    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] OP_SEED_MUL = 4'd2;
    localparam logic [OP_W-1:0] OP_SEED_ADD = 4'd3;
    localparam logic [OP_W-1:0] OP_RD_A     = 4'd4;
    localparam logic [OP_W-1:0] OP_RD_C     = 4'd5;
    localparam logic [OP_W-1:0] OP_RD_V     = 4'd6;
    localparam logic [OP_W-1:0] OP_RD_M     = 4'd7;
    localparam logic [OP_W-1:0] OP_FIN      = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT      = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] seed_idx;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             bound_max;
    } status_t;

endpackage

@@ rtl/wrpg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512a generator channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wrpg_req_if;
    logic                         valid;
    logic                         ready;
    logic [wrpg_pkg::REQ_W-1:0]  req_type;
    logic [wrpg_pkg::WORD_W-1:0] seed_value;
    logic [wrpg_pkg::WORD_W-1:0] bound;

    modport source (output valid, req_type, seed_value, bound, input ready);
    modport sink   (input valid, req_type, seed_value, bound, output ready);
endinterface

interface wrpg_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [wrpg_pkg::WORD_W-1:0] random_value;

    modport source (output valid, random_value, input ready);
    modport sink   (input valid, random_value, output ready);
endinterface

@@ rtl/well512_random_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512a random generator unit
// Usage: requests arrive as beats on the req channel (req_type, seed_value,
// bound); each request yields exactly one beat on the rsp channel carrying
// random_value. A seed request (code 0) fills the sixteen-word pool from
// seed_value and answers zero. A raw draw (code 1) advances the WELL512a
// recurrence and returns the new word. A bounded draw (code 2) returns that
// word modulo bound + 1, or the raw word when bound is all ones. Code 3
// leaves the state alone and answers zero. The first request after reset
// must be a seed.
// Sequencing: one request is in work at a time. A seed runs fifteen
// multiply and add pairs, a raw draw four pool reads through the single
// read port plus the final write, and a bounded draw follows the raw
// steps with the one-bit-per-cycle remainder unit unless bound is all
// ones. A new request is taken the cycle after the result is loaded.
// Reset clears the controller, the pool position and the output valid flag;
// the pool contents stay undefined until seeded. When the receiver stalls,
// the result beat holds in the output register; the next request may still
// be accepted and worked on, and its result waits until that register frees.
// ----------------------------------------------------------------------------
module well512_random_generator_unit (
    input  logic              clk,
    input  logic              rst_n,
    wrpg_req_if.sink          req,
    wrpg_rsp_if.source        rsp
);

    wrpg_pkg::cmd_t    cmd;
    wrpg_pkg::status_t status;

    // The controller owns sequencing and the handshakes.
    wrpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath owns the pool, the arithmetic and the output register.
    wrpg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req.req_type),
        .seed_value   (req.seed_value),
        .bound        (req.bound),
        .random_value (rsp.random_value)
    );

endmodule

@@ rtl/wrpg_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wrpg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/wrpg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512a generator controller
// Sequences seeding, the draw recurrence, the remainder unit and delivery.
// ----------------------------------------------------------------------------
module wrpg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output wrpg_pkg::cmd_t    cmd,
    input  wrpg_pkg::status_t status
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SEED_MUL = 4'd2;
    localparam logic [3:0] S_SEED_ADD = 4'd3;
    localparam logic [3:0] S_RD_A     = 4'd4;
    localparam logic [3:0] S_RD_C     = 4'd5;
    localparam logic [3:0] S_RD_V     = 4'd6;
    localparam logic [3:0] S_RD_M     = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0]                     state_reg, state_next;
    logic [wrpg_pkg::IDX_W-1:0]     seed_idx_reg, seed_idx_next;
    logic [wrpg_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        seed_idx_next  = seed_idx_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = wrpg_pkg::OP_NOP;
        cmd.seed_idx   = seed_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = wrpg_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                seed_idx_next = {{(wrpg_pkg::IDX_W-1){1'b0}}, 1'b1};
                case (status.req_type)
                    wrpg_pkg::REQ_SEED:    state_next = S_SEED_MUL;
                    wrpg_pkg::REQ_RAW:     state_next = S_RD_A;
                    wrpg_pkg::REQ_BOUNDED: state_next = S_RD_A;
                    default:               state_next = S_OUT;
                endcase
            end
            S_SEED_MUL:
            begin
                cmd.op     = wrpg_pkg::OP_SEED_MUL;
                state_next = S_SEED_ADD;
            end
            S_SEED_ADD:
            begin
                cmd.op = wrpg_pkg::OP_SEED_ADD;
                if (seed_idx_reg == wrpg_pkg::IDX_W'(wrpg_pkg::POOL_DEPTH - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    seed_idx_next = seed_idx_reg + 1'b1;
                    state_next    = S_SEED_MUL;
                end
            end
            S_RD_A:
            begin
                cmd.op     = wrpg_pkg::OP_RD_A;
                state_next = S_RD_C;
            end
            S_RD_C:
            begin
                cmd.op     = wrpg_pkg::OP_RD_C;
                state_next = S_RD_V;
            end
            S_RD_V:
            begin
                cmd.op     = wrpg_pkg::OP_RD_V;
                state_next = S_RD_M;
            end
            S_RD_M:
            begin
                cmd.op     = wrpg_pkg::OP_RD_M;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op       = wrpg_pkg::OP_FIN;
                div_cnt_next = '0;
                if ((status.req_type == wrpg_pkg::REQ_BOUNDED) && !status.bound_max)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                cmd.op       = wrpg_pkg::OP_DIV;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == wrpg_pkg::DIV_CNT_W'(wrpg_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Wait until the output register is free, then load it.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = wrpg_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_idx_reg  <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_idx_reg  <= seed_idx_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/wrpg_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512a generator datapath
// State pool memory, seeding multiplier, draw recurrence and a restoring
// remainder unit that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrpg_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wrpg_pkg::cmd_t               cmd,
    output wrpg_pkg::status_t            status,
    input  logic [wrpg_pkg::REQ_W-1:0]  req_type,
    input  logic [wrpg_pkg::WORD_W-1:0] seed_value,
    input  logic [wrpg_pkg::WORD_W-1:0] bound,
    output logic [wrpg_pkg::WORD_W-1:0] random_value
);

    localparam int W  = wrpg_pkg::WORD_W;
    localparam int IW = wrpg_pkg::IDX_W;

    logic [IW-1:0]          position_reg;
    logic [wrpg_pkg::REQ_W-1:0] req_type_reg;
    logic [W-1:0]           bound_reg;
    logic [W-1:0]           p_reg, prod_reg;
    logic [W-1:0]           a_reg, b_reg, c_reg, d_reg;
    logic [W-1:0]           word_reg, rem_reg, quo_reg, dsr_reg, out_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [W-1:0]  ram_wdata, ram_rdata;

    logic [W-1:0]  mul_in, seed_prod, seed_sum;
    logic [W-1:0]  b_next, c_mix, a_new, d_next, fin_word;
    logic [W:0]    div_trial, div_diff;
    logic [W-1:0]  rem_next, out_sel;
    logic [IW-1:0] pos_m;

    wrpg_ram #(
        .WIDTH (W),
        .DEPTH (wrpg_pkg::POOL_DEPTH)
    ) u_pool (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Seeding: w[i] = MULT * (w[i-1] ^ (w[i-1] >> 30)) + i.
    assign mul_in    = p_reg ^ (p_reg >> 30);
    assign seed_prod = wrpg_pkg::SEED_MULT * mul_in;
    assign seed_sum  = prod_reg + W'(cmd.seed_idx);

    // Draw recurrence, one pool word arriving per cycle.
    assign b_next   = a_reg ^ ram_rdata ^ (a_reg << 16) ^ (ram_rdata << 15);
    assign c_mix    = ram_rdata ^ (ram_rdata >> 11);
    assign a_new    = b_reg ^ c_mix;
    assign d_next   = a_new ^ ((a_new << 5) & wrpg_pkg::TEMPER_MASK);
    assign fin_word = ram_rdata ^ b_reg ^ d_reg ^ (ram_rdata << 2)
                      ^ (b_reg << 18) ^ (c_reg << 28);
    assign pos_m    = position_reg + wrpg_pkg::OFS_M;

    // Restoring remainder step; the partial remainder stays below the divisor.
    assign div_trial = {rem_reg, quo_reg[W-1]};
    assign div_diff  = div_trial - {1'b0, dsr_reg};
    assign rem_next  = div_diff[W] ? div_trial[W-1:0] : div_diff[W-1:0];

    always_comb
    begin
        case (req_type_reg)
            wrpg_pkg::REQ_RAW:     out_sel = word_reg;
            wrpg_pkg::REQ_BOUNDED: out_sel = (&bound_reg) ? word_reg : rem_reg;
            default:               out_sel = '0;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = position_reg;
        ram_wdata = a_new;
        ram_raddr = position_reg;
        case (cmd.op)
            wrpg_pkg::OP_LOAD:
            begin
                ram_we    = (req_type == wrpg_pkg::REQ_SEED);
                ram_waddr = '0;
                ram_wdata = seed_value;
            end
            wrpg_pkg::OP_SEED_ADD:
            begin
                ram_we    = 1'b1;
                ram_waddr = cmd.seed_idx;
                ram_wdata = seed_sum;
            end
            wrpg_pkg::OP_RD_C:
            begin
                ram_raddr = position_reg + wrpg_pkg::OFS_C;
            end
            wrpg_pkg::OP_RD_V:
            begin
                ram_raddr = position_reg + wrpg_pkg::OFS_V;
            end
            wrpg_pkg::OP_RD_M:
            begin
                ram_raddr = pos_m;
                ram_we    = 1'b1;
                ram_waddr = position_reg;
                ram_wdata = a_new;
            end
            wrpg_pkg::OP_FIN:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_m;
                ram_wdata = fin_word;
            end
            default:
            begin
                ram_raddr = position_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else if ((cmd.op == wrpg_pkg::OP_LOAD) && (req_type == wrpg_pkg::REQ_SEED))
        begin
            position_reg <= '0;
        end
        else if (cmd.op == wrpg_pkg::OP_FIN)
        begin
            position_reg <= pos_m;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            wrpg_pkg::OP_LOAD:
            begin
                req_type_reg <= req_type;
                bound_reg    <= bound;
                p_reg        <= seed_value;
            end
            wrpg_pkg::OP_SEED_MUL: prod_reg <= seed_prod;
            wrpg_pkg::OP_SEED_ADD: p_reg    <= seed_sum;
            wrpg_pkg::OP_RD_C:     a_reg    <= ram_rdata;
            wrpg_pkg::OP_RD_V:     b_reg    <= b_next;
            wrpg_pkg::OP_RD_M:
            begin
                c_reg <= c_mix;
                d_reg <= d_next;
            end
            wrpg_pkg::OP_FIN:
            begin
                word_reg <= fin_word;
                quo_reg  <= fin_word;
                rem_reg  <= '0;
                dsr_reg  <= bound_reg + 1'b1;
            end
            wrpg_pkg::OP_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_reg << 1;
            end
            wrpg_pkg::OP_OUT:      out_reg <= out_sel;
            default:
            begin
                out_reg <= out_reg;
            end
        endcase
    end

    assign status.req_type  = req_type_reg;
    assign status.bound_max = &bound_reg;
    assign random_value     = out_reg;

endmodule

@@ rtl/wrpg_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512a generator port checker
// Watches the channel ports of the top level and tracks beats in flight.
// ----------------------------------------------------------------------------
module wrpg_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [wrpg_pkg::WORD_W-1:0] random_value
);

    logic       in_acc, out_acc;
    logic [1:0] pending_reg, pending_next;

    assign in_acc       = in_valid && in_ready;
    assign out_acc      = out_valid && out_ready;
    assign pending_next = pending_reg + 2'(in_acc) - 2'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(random_value))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("request accepted while another is in work");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result with no request outstanding");

    a_bounded_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg < 2'd2)
        else $error("too many requests outstanding");

endmodule

bind well512_random_generator_unit wrpg_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .random_value (rsp.random_value)
);

@@ dv/tb_well512_random_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512a random generator unit testbench
// Sends seed, raw, bounded and unused-code requests through the request
// channel. A short directed table comes first, then randomized traffic in
// several idling phases. Every response beat is checked against a
// bench-side copy of the sixteen-word pool and its position.
// ----------------------------------------------------------------------------
module tb_well512_random_generator_unit;

    localparam int HALF_PERIOD  = 10;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASE_COUNT  = 5;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / PHASE_COUNT;
    localparam int MAX_GAP      = 60;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    // The longest legal quiet stretch is the long receiver hold-off plus one
    // bounded draw plus the longest sender gap. The limit is about ten times
    // that.
    localparam int QUIET_LIMIT  = 4000;

    // Idle percentages per random phase: none, sender idle, receiver
    // stalling, both, and a last phase without idling that opens with the
    // long receiver hold-off.
    localparam int SEND_IDLE [PHASE_COUNT] = '{0, 70, 0, 19, 0};
    localparam int RECV_IDLE [PHASE_COUNT] = '{0, 0, 70, 19, 0};

    // One row of directed stimulus. Where known is set, the value column is
    // the result that must come back; otherwise the pool model supplies it.
    typedef struct packed {
        logic [wrpg_pkg::REQ_W-1:0]  req_type;
        logic [wrpg_pkg::WORD_W-1:0] seed_value;
        logic [wrpg_pkg::WORD_W-1:0] bound;
        logic                        known;
        logic [wrpg_pkg::WORD_W-1:0] value;
    } stim_row_t;

    // One result beat still owed by the block.
    typedef struct packed {
        logic [wrpg_pkg::REQ_W-1:0]  req_type;
        logic [wrpg_pkg::WORD_W-1:0] value;
    } owed_word_t;

    localparam int DIR_ROWS = 22;
    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        // The very first request after reset has to be a seed.
        '{wrpg_pkg::REQ_SEED,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{wrpg_pkg::REQ_RAW,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_RAW,     32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
        // A bound of zero reduces modulo one, so the answer is always zero.
        '{wrpg_pkg::REQ_BOUNDED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // A bound of all ones must give back the raw word, not a modulo by 0.
        '{wrpg_pkg::REQ_BOUNDED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_BOUNDED, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_BOUNDED, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_BOUNDED, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_BOUNDED, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
        // The unused code answers zero and must leave the pool alone, which
        // the following raw draw shows.
        '{wrpg_pkg::REQ_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{wrpg_pkg::REQ_RAW,     32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_UNUSED,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{wrpg_pkg::REQ_SEED,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{wrpg_pkg::REQ_RAW,     32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_BOUNDED, 32'hFFFF_FFFF, 32'h0000_0009, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_SEED,    32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{wrpg_pkg::REQ_BOUNDED, 32'h0000_0000, 32'h0000_FFFF, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_RAW,     32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_SEED,    32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{wrpg_pkg::REQ_RAW,     32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{wrpg_pkg::REQ_SEED,    32'h1234_5678, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{wrpg_pkg::REQ_BOUNDED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000}
    };

    logic clk = 1'b0;
    logic rst_n;

    wrpg_req_if req_ch ();
    wrpg_rsp_if rsp_ch ();

    well512_random_generator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // Bench copy of the generator state. The pool is only read after the
    // first seed, so its starting contents do not matter.
    logic [wrpg_pkg::WORD_W-1:0] model_pool [wrpg_pkg::POOL_DEPTH];
    logic [wrpg_pkg::IDX_W-1:0]  model_pos;

    owed_word_t owed_words [$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_request   = 0;
    int         quiet_cycles   = 0;

    // Fills the pool from a seed word with the multiplier recurrence.
    function automatic void seed_model_pool(input logic [wrpg_pkg::WORD_W-1:0] seed_word);
        logic [wrpg_pkg::WORD_W-1:0] prev;
        model_pool[0] = seed_word;
        for (int i = 1; i < wrpg_pkg::POOL_DEPTH; i++)
        begin
            prev          = model_pool[i-1];
            model_pool[i] = wrpg_pkg::SEED_MULT * (prev ^ (prev >> 30))
                            + wrpg_pkg::WORD_W'(i);
        end
        model_pos = '0;
    endfunction

    // Advances the WELL512a recurrence by one word. Index sums are kept at
    // four bits so they wrap around the pool.
    function automatic logic [wrpg_pkg::WORD_W-1:0] advance_model_pool();
        logic [wrpg_pkg::WORD_W-1:0] a, b, c, d;
        logic [wrpg_pkg::IDX_W-1:0]  k, kc, kv;
        k  = model_pos;
        kc = k + wrpg_pkg::OFS_C;
        kv = k + wrpg_pkg::OFS_V;
        a  = model_pool[k];
        c  = model_pool[kc];
        b  = a ^ c ^ (a << 16) ^ (c << 15);
        c  = model_pool[kv];
        c  = c ^ (c >> 11);
        a  = b ^ c;
        model_pool[k] = a;
        d  = a ^ ((a << 5) & wrpg_pkg::TEMPER_MASK);
        k  = k + wrpg_pkg::OFS_M;
        model_pos = k;
        a  = model_pool[k];
        model_pool[k] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
        return model_pool[k];
    endfunction

    // Result word for one accepted request; updates the bench state.
    function automatic logic [wrpg_pkg::WORD_W-1:0] predict_random_value(
        input logic [wrpg_pkg::REQ_W-1:0]  req_type,
        input logic [wrpg_pkg::WORD_W-1:0] seed_value,
        input logic [wrpg_pkg::WORD_W-1:0] bound
    );
        logic [wrpg_pkg::WORD_W-1:0] word, modulus;
        word = '0;
        case (req_type)
            wrpg_pkg::REQ_SEED: seed_model_pool(seed_value);
            wrpg_pkg::REQ_RAW:  word = advance_model_pool();
            wrpg_pkg::REQ_BOUNDED:
            begin
                word    = advance_model_pool();
                modulus = bound + 32'd1;
                // bound + 1 wraps to zero for all ones; the word then
                // passes through unreduced.
                if (bound != '1)
                    word = word % modulus;
            end
            default: ;
        endcase
        return word;
    endfunction

    // Offers one request beat after a random idle gap and waits until the
    // block takes it. Valid stays high when the next beat follows at once.
    task automatic send_request(
        input logic [wrpg_pkg::REQ_W-1:0]  req_type,
        input logic [wrpg_pkg::WORD_W-1:0] seed_value,
        input logic [wrpg_pkg::WORD_W-1:0] bound,
        input logic                        known,
        input logic [wrpg_pkg::WORD_W-1:0] known_value
    );
        int                          gap;
        logic [wrpg_pkg::WORD_W-1:0] word;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req_type;
        req_ch.seed_value <= seed_value;
        req_ch.bound      <= bound;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        word = predict_random_value(req_type, seed_value, bound);
        owed_words.push_back('{req_type, known ? known_value : word});
    endtask

    // Random bound shapes: zero, all ones, near all ones, small values,
    // masks, single bits and full-width values.
    function automatic logic [wrpg_pkg::WORD_W-1:0] pick_bound();
        logic [wrpg_pkg::WORD_W-1:0] b;
        case ($urandom_range(0, 9))
            0:       b = '0;
            1:       b = '1;
            2:       b = $urandom_range(1, 15);
            3:       b = (32'd1 << $urandom_range(0, 31)) - 32'd1;
            4:       b = $urandom_range(0, 255);
            5, 6:    b = $urandom;
            7:       b = 32'hFFFF_FFFF - $urandom_range(0, 3);
            8:       b = 32'd1 << $urandom_range(0, 31);
            default: b = $urandom >> $urandom_range(0, 31);
        endcase
        return b;
    endfunction

    // Mostly draws with random content; reseeds and unused codes now and
    // then. A seed always precedes these, so no draw reads an empty pool.
    task automatic send_random_request();
        int                         pick;
        logic [wrpg_pkg::REQ_W-1:0] req_type;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            req_type = wrpg_pkg::REQ_SEED;
        else if (pick < 8)
            req_type = wrpg_pkg::REQ_UNUSED;
        else if (pick < 52)
            req_type = wrpg_pkg::REQ_RAW;
        else
            req_type = wrpg_pkg::REQ_BOUNDED;
        send_request(req_type, $urandom, pick_bound(), 1'b0, '0);
    endtask

    // Drops valid and waits until every owed result beat has come back.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: reset, the directed table, then the random phases.
    initial
    begin
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= wrpg_pkg::REQ_SEED;
        req_ch.seed_value <= '0;
        req_ch.bound      <= '0;
        rst_n             <= 1'b0;
        model_pos          = '0;
        for (int i = 0; i < wrpg_pkg::POOL_DEPTH; i++)
            model_pool[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_request(DIR_TAB[r].req_type, DIR_TAB[r].seed_value, DIR_TAB[r].bound,
                         DIR_TAB[r].known, DIR_TAB[r].value);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_IDLE[ph];
            // In the last phase the receiver holds off while the sender keeps
            // offering beats, so the block fills up and stalls its input.
            if (ph == PHASE_COUNT - 1)
                hold_request = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Halfway through each phase the sender pauses until the
                // block has delivered everything it owes.
                if (n == PHASE_ITEMS / 2)
                    wait_for_drain();
                send_random_request();
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stalls at the phase rate, plus the long hold-off,
    // which is counted here cycle by cycle.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Response checker: each accepted beat is matched with the oldest owed
    // result.
    always @(posedge clk)
    begin
        owed_word_t owed;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (owed_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with none owed, random_value=%08h",
                             $realtime, rsp_ch.random_value);
            end
            else
            begin
                owed = owed_words.pop_front();
                if (rsp_ch.random_value !== owed.value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: random_value mismatch, req_type=%0d exp=%08h got=%08h",
                                 $realtime, owed.req_type, owed.value,
                                 rsp_ch.random_value);
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too
    // long.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

@@ files.f @@
rtl/wrpg_pkg.sv
rtl/wrpg_if.sv
rtl/wrpg_ram.sv
rtl/wrpg_ctrl.sv
rtl/wrpg_dp.sv
rtl/well512_random_generator_unit.sv
rtl/wrpg_chk.sv
dv/tb_well512_random_generator_unit.sv
